/* sv/rlfg_pkg.sv */
package rlfg_pkg;

   localparam int EffectCount = 7;
   localparam int LogoCount   = 3;
   localparam int LedTotal    = LogoCount + EffectCount;
   localparam int CntW        = $clog2(LedTotal + 1);
   localparam int BufW        = $clog2(LedTotal);
   localparam int AddrW       = 5;

   localparam logic [10:0] PitchReset     = 11'd151;
   localparam logic [7:0]  SpeedMinReset  = 8'd4;
   localparam logic [7:0]  SpeedMaxReset  = 8'd100;
   localparam logic [31:0] HoldReset      = 32'd1000000;
   localparam logic [31:0] DecayReset     = 32'd200000;

   // floor(s * 95 / 100) == (s * DecayMul) >> DecayShift for all 8-bit s
   localparam logic [18:0] DecayMul   = 19'd498085;
   localparam int          DecayShift = 19;

   localparam logic [1:0] CmdFrame = 2'd0;
   localparam logic [1:0] CmdStim  = 2'd1;
   localparam logic [1:0] CmdHost  = 2'd2;

   localparam logic [2:0] RegPitch    = 3'd0;
   localparam logic [2:0] RegSpeedMin = 3'd1;
   localparam logic [2:0] RegSpeedMax = 3'd2;
   localparam logic [2:0] RegHold     = 3'd3;
   localparam logic [2:0] RegDecay    = 3'd4;

   localparam logic [2:0] SegRedUp     = 3'd0;
   localparam logic [2:0] SegBlueDown  = 3'd1;
   localparam logic [2:0] SegGreenUp   = 3'd2;
   localparam logic [2:0] SegRedDown   = 3'd3;
   localparam logic [2:0] SegBlueUp    = 3'd4;
   localparam logic [2:0] SegGreenDown = 3'd5;

   typedef struct packed {
      logic [10:0] pitch;
      logic [7:0]  speed_min;
      logic [7:0]  speed_max;
      logic [31:0] hold_us;
      logic [31:0] decay_interval_us;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        raw;
      logic [31:0] idx;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } wheel_req_type;

   typedef struct packed {
      logic        valid;
      logic [23:0] pix;
   } wheel_rsp_type;

   // (x mod 6) via 2-bit digit sums for mod 3 plus parity
   function automatic logic [2:0] wheel_seg(input logic [23:0] x);
      logic [5:0] s1;
      logic [3:0] s2;
      logic [2:0] s3;
      logic [2:0] m3;
      s1 = '0;
      for (int k = 0; k < 12; k++) begin
         s1 = s1 + 6'(x[2*k +: 2]);
      end
      s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
      s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
      m3 = (s3 >= 3'd3) ? s3 - 3'd3 : s3;
      return (m3[0] == x[0]) ? m3 : m3 + 3'd3;
   endfunction

endpackage

/* sv/rlfg_if.sv */
interface rlfg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [63:0] now_us;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;

   modport source (output valid, command, now_us, red, green, blue, input ready);
   modport sink   (input valid, command, now_us, red, green, blue, output ready);
endinterface

interface rlfg_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  led_index;
   logic [23:0] led_color;
   logic        last;

   modport source (output valid, led_index, led_color, last, input ready);
   modport sink   (input valid, led_index, led_color, last, output ready);
endinterface

/* sv/rainbow_led_frame_generator_unit.sv */
// Rainbow LED frame generator.
// req_chan takes one command word per handshake: frame (0), stimulate (1)
// or host logo color (2), with the current time in now_us. rsp_chan gives
// one pixel word per LED for each frame: logo LEDs first, then the effect
// LEDs, with last set on the final word. Stimulate and host color give no
// words; unused command codes are dropped.
// Registers sit on the csr_ APB port; write them only while the block idles.
// A frame first advances the rotator (StRot) and sets the base index
// (StBase), then feeds one wheel index per cycle into the two-stage
// wheel/gamma unit. The shared wheel/gamma unit handles one LED per
// cycle. Stimulate leaves the block ready; host color makes one pass
// through the unit.
// Pixels queue in a small frame buffer, so a stalled receiver holds the
// current word steady while the unit keeps going; req_chan stays not ready
// until every word of the frame has been taken.
// Reset clears rotator, hold and decay times and host color, sets speed to
// 4 and the registers to their defaults.
module rainbow_led_frame_generator_unit (
   input  logic                       clock,
   input  logic                       reset,
   rlfg_req_if.sink                   req_chan,
   rlfg_rsp_if.source                 rsp_chan,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [rlfg_pkg::AddrW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [6:0] {
      StIdle  = 7'b0000001,
      StRot   = 7'b0000010,
      StBase  = 7'b0000100,
      StRun   = 7'b0001000,
      StDecay = 7'b0010000,
      StDrain = 7'b0100000,
      StHost  = 7'b1000000
   } state_type;

   localparam int CntW = rlfg_pkg::CntW;
   localparam int BufW = rlfg_pkg::BufW;

   rlfg_pkg::cfg_type       cfg;
   rlfg_pkg::wheel_req_type wreq;
   rlfg_pkg::wheel_rsp_type wrsp;

   state_type   state_ff, state_in;
   logic [63:0] now_ff, now_in;
   logic [31:0] rotator_ff, rotator_in;
   logic [7:0]  speed_ff, speed_in;
   logic [63:0] hold_until_ff, hold_until_in;
   logic [63:0] next_decay_ff, next_decay_in;
   logic [23:0] host_colour_ff, host_colour_in;
   logic        hold_act_ff, hold_act_in;
   logic        decay_due_ff, decay_due_in;
   logic [31:0] idx_ff, idx_in;
   logic [CntW-1:0] issue_ff, issue_in;
   logic [CntW-1:0] wr_ff, wr_in;
   logic [CntW-1:0] rd_ff, rd_in;
   logic [23:0] pix_buf_ff [rlfg_pkg::LedTotal];
   logic [23:0] wr_pix;
   logic        req_take;
   logic        rsp_take;
   logic [26:0] decay_prod;

   rlfg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rlfg_wheel u_wheel (
      .clock (clock),
      .reset (reset),
      .wreq  (wreq),
      .wrsp  (wrsp)
   );

   assign req_chan.ready = (state_ff == StIdle);
   assign req_take       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = (rd_ff != wr_ff);
   assign rsp_chan.led_color = pix_buf_ff[rd_ff[BufW-1:0]];
   assign rsp_chan.led_index = 4'(rd_ff);
   assign rsp_chan.last      = (rd_ff == CntW'(rlfg_pkg::LedTotal - 1));
   assign rsp_take           = rsp_chan.valid && rsp_chan.ready;

   assign wreq.valid = (state_ff == StRun) ||
                       (req_take && (req_chan.command == rlfg_pkg::CmdHost));
   assign wreq.raw   = (state_ff == StIdle);
   assign wreq.idx   = idx_ff;
   assign wreq.red   = req_chan.red;
   assign wreq.green = req_chan.green;
   assign wreq.blue  = req_chan.blue;

   assign decay_prod = 27'(speed_ff) * 27'(rlfg_pkg::DecayMul);

   assign wr_pix = (hold_act_ff && (wr_ff < CntW'(rlfg_pkg::LogoCount))) ?
                   host_colour_ff : wrsp.pix;

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      rotator_in     = rotator_ff;
      speed_in       = speed_ff;
      hold_until_in  = hold_until_ff;
      next_decay_in  = next_decay_ff;
      host_colour_in = host_colour_ff;
      hold_act_in    = hold_act_ff;
      decay_due_in   = decay_due_ff;
      idx_in         = idx_ff;
      issue_in       = issue_ff;
      wr_in          = wr_ff;
      rd_in          = rsp_take ? rd_ff + CntW'(1) : rd_ff;

      if (wrsp.valid && (state_ff != StHost)) begin
         wr_in = wr_ff + CntW'(1);
      end

      case (state_ff)
         StIdle: begin
            if (req_take) begin
               now_in = req_chan.now_us;
               case (req_chan.command)
                  rlfg_pkg::CmdFrame: state_in = StRot;
                  rlfg_pkg::CmdStim: begin
                     if (speed_ff < cfg.speed_max) begin
                        speed_in = speed_ff + 8'd1;
                     end
                  end
                  rlfg_pkg::CmdHost: begin
                     hold_until_in = req_chan.now_us + 64'(cfg.hold_us);
                     state_in      = StHost;
                  end
                  default: state_in = StIdle;
               endcase
            end
         end
         StRot: begin
            rotator_in   = rotator_ff + 32'(speed_ff);
            hold_act_in  = (now_ff < hold_until_ff);
            decay_due_in = (now_ff >= next_decay_ff);
            state_in     = StBase;
         end
         StBase: begin
            idx_in   = rotator_ff + 32'(cfg.pitch) * 32'(rlfg_pkg::EffectCount);
            issue_in = '0;
            wr_in    = '0;
            rd_in    = '0;
            state_in = StRun;
         end
         StRun: begin
            idx_in   = (issue_ff == CntW'(rlfg_pkg::LogoCount - 1)) ?
                       rotator_ff : idx_ff + 32'(cfg.pitch);
            issue_in = issue_ff + CntW'(1);
            if (issue_ff == CntW'(rlfg_pkg::LedTotal - 1)) begin
               state_in = StDecay;
            end
         end
         StDecay: begin
            if (decay_due_ff) begin
               next_decay_in = now_ff + 64'(cfg.decay_interval_us);
               if (speed_ff > cfg.speed_min) begin
                  speed_in = decay_prod[rlfg_pkg::DecayShift +: 8];
               end
            end
            state_in = StDrain;
         end
         StDrain: begin
            if (rsp_take && rsp_chan.last) begin
               state_in = StIdle;
            end
         end
         StHost: begin
            if (wrsp.valid) begin
               host_colour_in = wrsp.pix;
               state_in       = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= StIdle;
         rotator_ff     <= '0;
         speed_ff       <= rlfg_pkg::SpeedMinReset;
         hold_until_ff  <= '0;
         next_decay_ff  <= '0;
         host_colour_ff <= '0;
         hold_act_ff    <= 1'b0;
         decay_due_ff   <= 1'b0;
         issue_ff       <= '0;
         wr_ff          <= '0;
         rd_ff          <= '0;
      end else begin
         state_ff       <= state_in;
         rotator_ff     <= rotator_in;
         speed_ff       <= speed_in;
         hold_until_ff  <= hold_until_in;
         next_decay_ff  <= next_decay_in;
         host_colour_ff <= host_colour_in;
         hold_act_ff    <= hold_act_in;
         decay_due_ff   <= decay_due_in;
         issue_ff       <= issue_in;
         wr_ff          <= wr_in;
         rd_ff          <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      idx_ff <= idx_in;
      if (wrsp.valid && (state_ff != StHost)) begin
         pix_buf_ff[wr_ff[BufW-1:0]] <= wr_pix;
      end
   end

endmodule

/* sv/rlfg_csr.sv */
module rlfg_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [rlfg_pkg::AddrW-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output rlfg_pkg::cfg_type         cfg
);

   rlfg_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        sel;
   logic              wr_en;

   assign sel        = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            rlfg_pkg::RegPitch:    cfg_in.pitch             = csr_pwdata[10:0];
            rlfg_pkg::RegSpeedMin: cfg_in.speed_min         = csr_pwdata[7:0];
            rlfg_pkg::RegSpeedMax: cfg_in.speed_max         = csr_pwdata[7:0];
            rlfg_pkg::RegHold:     cfg_in.hold_us           = csr_pwdata;
            rlfg_pkg::RegDecay:    cfg_in.decay_interval_us = csr_pwdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         rlfg_pkg::RegPitch:    csr_prdata = 32'(cfg_ff.pitch);
         rlfg_pkg::RegSpeedMin: csr_prdata = 32'(cfg_ff.speed_min);
         rlfg_pkg::RegSpeedMax: csr_prdata = 32'(cfg_ff.speed_max);
         rlfg_pkg::RegHold:     csr_prdata = cfg_ff.hold_us;
         rlfg_pkg::RegDecay:    csr_prdata = cfg_ff.decay_interval_us;
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pitch             <= rlfg_pkg::PitchReset;
         cfg_ff.speed_min         <= rlfg_pkg::SpeedMinReset;
         cfg_ff.speed_max         <= rlfg_pkg::SpeedMaxReset;
         cfg_ff.hold_us           <= rlfg_pkg::HoldReset;
         cfg_ff.decay_interval_us <= rlfg_pkg::DecayReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/rlfg_wheel.sv */
module rlfg_wheel (
   input  logic                    clock,
   input  logic                    reset,
   input  rlfg_pkg::wheel_req_type wreq,
   output rlfg_pkg::wheel_rsp_type wrsp
);

   logic [2:0]  seg;
   logic [7:0]  inc;
   logic [7:0]  dec;
   logic [7:0]  r_in, g_in, b_in;
   logic [7:0]  r_ff, g_ff, b_ff;
   logic        s1_valid_ff;
   logic [15:0] r_sq, g_sq, b_sq;
   logic        out_valid_ff;
   logic [23:0] out_pix_ff;

   assign seg = rlfg_pkg::wheel_seg(wreq.idx[31:8]);
   assign inc = wreq.idx[7:0];
   assign dec = ~inc;

   always_comb begin
      if (wreq.raw) begin
         r_in = wreq.red;
         g_in = wreq.green;
         b_in = wreq.blue;
      end else begin
         case (seg)
            rlfg_pkg::SegRedUp:    begin r_in = inc;   g_in = 8'd0;  b_in = 8'd255; end
            rlfg_pkg::SegBlueDown: begin r_in = 8'd255; g_in = 8'd0;  b_in = dec;    end
            rlfg_pkg::SegGreenUp:  begin r_in = 8'd255; g_in = inc;   b_in = 8'd0;   end
            rlfg_pkg::SegRedDown:  begin r_in = dec;   g_in = 8'd255; b_in = 8'd0;   end
            rlfg_pkg::SegBlueUp:   begin r_in = 8'd0;  g_in = 8'd255; b_in = inc;    end
            default:               begin r_in = 8'd0;  g_in = dec;    b_in = 8'd255; end
         endcase
      end
   end

   // gamma: c*c >> 8
   assign r_sq = 16'(r_ff) * 16'(r_ff);
   assign g_sq = 16'(g_ff) * 16'(g_ff);
   assign b_sq = 16'(b_ff) * 16'(b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= wreq.valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      r_ff       <= r_in;
      g_ff       <= g_in;
      b_ff       <= b_in;
      out_pix_ff <= {g_sq[15:8], r_sq[15:8], b_sq[15:8]};
   end

   assign wrsp.valid = out_valid_ff;
   assign wrsp.pix   = out_pix_ff;

endmodule
